// ===== hdl/json_keyed_object_span_finder_unit_assert.svh =====
// Assertion macros for the keyed object span finder.
`ifndef JSON_KEYED_OBJECT_SPAN_FINDER_UNIT_ASSERT_SVH
`define JSON_KEYED_OBJECT_SPAN_FINDER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define JKSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the cycle after the trigger.
`define JKSF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/jksf_pkg.sv =====
// Shared constants, types and helpers of the keyed object span finder.
`default_nettype none

package jksf_pkg;

  localparam int KEY_MAX    = 16;
  localparam int WIN_LEN    = KEY_MAX + 2;
  localparam int KEY_LEN_W  = 5;
  localparam int WIN_IDX_W  = $clog2(WIN_LEN + 1);
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int POS_BITS   = 32;
  localparam int DEPTH_BITS = 16;

  typedef logic [7:0] byte_t;

  localparam byte_t CH_NUL    = 8'h00;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_COLON  = 8'h3A;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_LBRACE = 8'h7B;
  localparam byte_t CH_RBRACE = 8'h7D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2
  } cfg_idx_e;

  // Per-cell control: shift strobe, clear strobe, expected byte, compare enable
  typedef struct packed {
    logic  shift;
    logic  clr;
    byte_t want;
    logic  care;
  } cell_ctl_t;

  // Expected byte at window cell k (cell 0 = newest) for a pattern of plen bytes
  function automatic byte_t want_byte(input logic [8*KEY_MAX-1:0] key,
                                      input logic [WIN_IDX_W-1:0] plen,
                                      input logic [WIN_IDX_W-1:0] k);
    logic [WIN_IDX_W-1:0] j;
    byte_t                w;
    j = plen - k - WIN_IDX_W'(2);
    w = CH_QUOTE;
    if (k != '0 && k != plen - WIN_IDX_W'(1)) begin
      for (int i = 0; i < KEY_MAX; i++) begin
        if (j == WIN_IDX_W'(i)) w = key[8*i +: 8];
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/jksf_win_cell.sv =====
// One cell of the byte window: holds a byte, passes it on, compares the incoming byte.
`default_nettype none

module jksf_win_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  jksf_pkg::cell_ctl_t  ctl_i,
  input  wire  [7:0]           byte_i,
  input  wire                  valid_i,
  output logic [7:0]           byte_o,
  output logic                 valid_o,
  output logic                 hit_o
);
  import jksf_pkg::*;

  byte_t byte_q;
  logic  valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.clr) begin
      valid_q <= 1'b0;
    end else if (ctl_i.shift) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  // hit on the content this cell takes at the coming shift
  assign hit_o   = !ctl_i.care || (valid_i && (byte_i == ctl_i.want));
  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== hdl/json_keyed_object_span_finder_unit.sv =====
// Keyed object span finder: top level with key window, scan control and result register.
// The result for a byte appears on m_axis in the cycle after that byte's transfer.
// Throughput: one text byte per cycle; the row of window cells compares all key
//   positions in parallel and the brace tracker updates in the same cycle.
// Input stalls only while an unclaimed result sits in the output register.
// Reset (rst_ni low, asynchronous) clears the key registers, the window valid bits,
//   the scan state and the output valid; no clearing pass follows.
`default_nettype none

module json_keyed_object_span_finder_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [63:0] cfg_data_i,
  // text byte stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire         s_axis_tlast,   // last
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] span_start, [63:32] span_end
  output logic        m_axis_tuser    // [0] found
);
  import jksf_pkg::*;

  // scan phases
  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_COLON  = 3'd1;
  localparam logic [2:0] PH_SKIPWS = 3'd2;
  localparam logic [2:0] PH_OBJECT = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // ---------------------------------------------------------------------------
  // Configuration registers. Always ready; the host must write them only while no
  // byte or result is in flight; the block itself does not enforce this.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]     key_lo_q, key_hi_q;
  logic [KEY_LEN_W-1:0] key_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      key_len_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEY_LOW:  key_lo_q  <= cfg_data_i;
        CFG_KEY_HIGH: key_hi_q  <= cfg_data_i;
        CFG_KEY_LEN:  key_len_q <= cfg_data_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern: quote, clamped key, quote.
  logic [KEY_LEN_W-1:0] len_eff;
  logic [WIN_IDX_W-1:0] plen;
  logic [8*KEY_MAX-1:0] key_all;

  assign len_eff = (key_len_q > KEY_LEN_W'(KEY_MAX)) ? KEY_LEN_W'(KEY_MAX) : key_len_q;
  assign plen    = WIN_IDX_W'(len_eff) + WIN_IDX_W'(2);
  assign key_all = {key_hi_q, key_lo_q};

  // ---------------------------------------------------------------------------
  // Handshake and decoded input byte
  // ---------------------------------------------------------------------------
  logic  m_valid_q;
  logic  in_xfer;
  byte_t b;
  logic  lst;

  // Output register frees up in the same cycle it is taken.
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign lst           = s_axis_tlast;

  logic [2:0] phase_q, phase_d;

  // ---------------------------------------------------------------------------
  // Key window: a row of cells, newest byte in cell 0, shifting toward the tail.
  // Each cell checks the byte it is about to take; the AND of all hits is a match.
  // ---------------------------------------------------------------------------
  cell_ctl_t          ctl  [WIN_LEN];
  byte_t              cbyte[WIN_LEN];
  logic [WIN_LEN-1:0] cvalid;
  logic [WIN_LEN-1:0] chit;
  logic               win_shift, win_clr, win_hit;

  assign win_shift = in_xfer && (b != CH_NUL) && (phase_q == PH_SEARCH);
  assign win_clr   = in_xfer && lst;
  assign win_hit   = &chit;

  for (genvar k = 0; k < WIN_LEN; k++) begin : g_cell
    logic [7:0] din;
    logic       vin;

    if (k == 0) begin : g_head
      assign din = b;
      assign vin = 1'b1;
    end else begin : g_link
      assign din = cbyte[k-1];
      assign vin = cvalid[k-1];
    end

    assign ctl[k].shift = win_shift;
    assign ctl[k].clr   = win_clr;
    assign ctl[k].want  = want_byte(key_all, plen, WIN_IDX_W'(k));
    assign ctl[k].care  = WIN_IDX_W'(k) < plen;

    jksf_win_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[k]),
      .byte_i  (din),
      .valid_i (vin),
      .byte_o  (cbyte[k]),
      .valid_o (cvalid[k]),
      .hit_o   (chit[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Scan control: colon seek, whitespace skip, brace tracking
  // ---------------------------------------------------------------------------
  logic [POS_BITS-1:0]   pos_q, pos_d, start_q, start_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic                  instr_q, instr_d, esc_q, esc_d;
  logic                  emit, emit_found;
  logic                  is_ws;

  assign is_ws = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    start_d    = start_q;
    depth_d    = depth_q;
    instr_d    = instr_q;
    esc_d      = esc_q;
    emit       = 1'b0;
    emit_found = 1'b0;
    if (in_xfer) begin
      pos_d = pos_q + POS_BITS'(1);
      if (b == CH_NUL) begin
        // end of text: report not found unless a result already went out
        if (phase_q != PH_DONE) begin
          emit    = 1'b1;
          phase_d = PH_DONE;
        end
      end else begin
        unique case (phase_q)
          PH_SEARCH: begin
            if (win_hit) phase_d = PH_COLON;
          end
          PH_COLON: begin
            if (b == CH_COLON) phase_d = PH_SKIPWS;
          end
          PH_SKIPWS: begin
            if (!is_ws) begin
              if (b == CH_LBRACE) begin
                start_d = pos_q;
                depth_d = DEPTH_BITS'(1);
                instr_d = 1'b0;
                esc_d   = 1'b0;
                phase_d = PH_OBJECT;
              end else begin
                emit    = 1'b1;
                phase_d = PH_DONE;
              end
            end
          end
          PH_OBJECT: begin
            if (instr_q) begin
              if (esc_q)                 esc_d   = 1'b0;
              else if (b == CH_BSLASH)   esc_d   = 1'b1;
              else if (b == CH_QUOTE)    instr_d = 1'b0;
            end else if (b == CH_QUOTE) begin
              instr_d = 1'b1;
            end else if (b == CH_LBRACE) begin
              // saturate at all ones
              if (depth_q != '1) depth_d = depth_q + DEPTH_BITS'(1);
            end else if (b == CH_RBRACE) begin
              depth_d = depth_q - DEPTH_BITS'(1);
              if (depth_q == DEPTH_BITS'(1)) begin
                emit       = 1'b1;
                emit_found = 1'b1;
                phase_d    = PH_DONE;
              end
            end
          end
          PH_DONE: ;
          default: ;
        endcase
      end
      // last byte: late not-found, then back to a fresh scan
      if (lst) begin
        if (phase_q != PH_DONE && !emit) emit = 1'b1;
        phase_d = PH_SEARCH;
        pos_d   = '0;
        start_d = '0;
        depth_d = '0;
        instr_d = 1'b0;
        esc_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      pos_q   <= '0;
      start_q <= '0;
      depth_q <= '0;
      instr_q <= 1'b0;
      esc_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      depth_q <= depth_d;
      instr_q <= instr_d;
      esc_q   <= esc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. Not-found results carry zero offsets.
  // ---------------------------------------------------------------------------
  logic        m_valid_d;
  logic        found_q;
  logic [63:0] res_q;

  assign m_valid_d = emit ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      found_q <= emit_found;
      res_q   <= emit_found ? {pos_q + POS_BITS'(1), start_q} : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = found_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "json_keyed_object_span_finder_unit_assert.svh"

  `JKSF_ASSERT_ALWAYS(a_depth_live, (phase_q != PH_OBJECT) || (depth_q != '0), "object phase with zero depth")
  `JKSF_ASSERT_ALWAYS(a_nf_zero, !(m_valid_q && !found_q) || (res_q == '0), "not-found result with nonzero span")
  `JKSF_ASSERT_ALWAYS(a_no_overrun, !(m_valid_q && !m_axis_tready) || !s_axis_tready, "input taken over a held result")
  `JKSF_ASSERT_NEXT(a_last_clears, in_xfer && lst, (phase_q == PH_SEARCH) && (cvalid == '0), "scan not cleared after last byte")

endmodule

`default_nettype wire

// ===== sim/json_keyed_object_span_finder_unit_tb.sv =====
// Self-checking testbench for the keyed object span finder top level.
module json_keyed_object_span_finder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jksf_pkg::*;

  // A correct run moves under a thousand bytes, even with heavy idling on both
  // sides and the long receiver hold-off.
  localparam int CYCLE_LIMIT  = 200_000;
  // The result is registered when its byte is taken and shows in the next cycle; the
  // drain wait also covers bytes that cause no result but may still be in flight.
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 750;
  // Every text ends in exactly one result, so this keeps each random phase
  // going until that phase alone has produced at least 16 results.
  localparam int MIN_SPANS_PER_PHASE = 16;
  localparam int TEXTS_PER_KEY       = 6;
  localparam int HOLD_OFF_CYCLES     = 300;
  localparam int MAX_NEST            = 4;

  // Scan progress inside one text.
  typedef enum logic [2:0] {
    ST_FIND_KEY,
    ST_FIND_COLON,
    ST_SKIP_BLANK,
    ST_IN_OBJECT,
    ST_IDLE
  } scan_state_e;

  // One expected result: found flag and the object's byte span.
  typedef struct packed {
    logic                found;
    logic [POS_BITS-1:0] open_at;
    logic [POS_BITS-1:0] close_after;
  } span_t;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] text_byte
  logic        s_axis_tlast;   // last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [31:0] span_start, [63:32] span_end
  logic        m_axis_tuser;   // [0] found

  json_keyed_object_span_finder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Span predictor: own copy of key registers and scan state
  // ---------------------------------------------------------------------------
  logic [63:0]           key_lo;
  logic [63:0]           key_hi;
  logic [KEY_LEN_W-1:0]  key_len;

  scan_state_e           scan_st;
  byte_t                 recent_bytes [WIN_LEN];  // [0] = newest byte
  int                    recent_cnt;
  logic [POS_BITS-1:0]   text_pos;
  logic [POS_BITS-1:0]   obj_open_pos;
  logic [DEPTH_BITS-1:0] nest_lvl;
  bit                    in_quotes;
  bit                    after_bslash;

  span_t span_q [$];   // spans still owed by the DUT, oldest first

  int err_cnt         = 0;
  int items_taken     = 0;
  int texts_sent      = 0;
  int spans_predicted = 0;
  int spans_checked   = 0;
  int found_cnt       = 0;
  int cycle_cnt       = 0;

  int src_idle_pct    = 0;
  int dst_idle_pct    = 0;
  int rx_hold_cycles  = 0;

  byte_t text_buf [$];  // text under construction

  function automatic int key_eff_len();
    return (key_len > KEY_MAX) ? KEY_MAX : int'(key_len);
  endfunction

  // Bytes past index 15 are zero and can never match text.
  function automatic byte_t key_byte_at(int i);
    if (i < 8) return key_lo[8*i +: 8];
    if (i < 16) return key_hi[8*(i-8) +: 8];
    return CH_NUL;
  endfunction

  // Window holds '"' key '"' with the closing quote newest.
  function automatic bit quoted_key_seen();
    int    plen;
    int    m;
    byte_t want;
    plen = key_eff_len() + 2;
    if (recent_cnt < plen) return 1'b0;
    for (int k = 0; k < plen; k++) begin
      m = plen - 1 - k;
      want = (m == 0 || m == plen - 1) ? CH_QUOTE : key_byte_at(m - 1);
      if (recent_bytes[k] != want) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit is_blank(byte_t b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic void restart_scan();
    scan_st = ST_FIND_KEY;
    foreach (recent_bytes[i]) recent_bytes[i] = CH_NUL;
    recent_cnt   = 0;
    text_pos     = '0;
    obj_open_pos = '0;
    nest_lvl     = '0;
    in_quotes    = 1'b0;
    after_bslash = 1'b0;
  endfunction

  function automatic void push_span(bit f, logic [POS_BITS-1:0] s, logic [POS_BITS-1:0] e);
    span_t sp;
    sp.found       = f;
    sp.open_at     = s;
    sp.close_after = e;
    span_q.push_back(sp);
    spans_predicted++;
  endfunction

  function automatic void set_reg(cfg_idx_e idx, logic [63:0] v);
    case (idx)
      CFG_KEY_LOW:  key_lo = v;
      CFG_KEY_HIGH: key_hi = v;
      CFG_KEY_LEN:  key_len = v[KEY_LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the scan by one accepted byte; queue the result it causes, if any.
  function automatic void scan_byte(byte_t b, bit lst);
    bit emitted;
    emitted = 1'b0;
    if (b == CH_NUL) begin
      // zero byte ends the text; later bytes are ignored until last
      if (scan_st != ST_IDLE) begin
        push_span(1'b0, '0, '0);
        emitted = 1'b1;
        scan_st = ST_IDLE;
      end
    end else begin
      case (scan_st)
        ST_FIND_KEY: begin
          for (int i = WIN_LEN - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
          recent_bytes[0] = b;
          if (recent_cnt < WIN_LEN) recent_cnt++;
          if (quoted_key_seen()) scan_st = ST_FIND_COLON;
        end
        ST_FIND_COLON: begin
          if (b == CH_COLON) scan_st = ST_SKIP_BLANK;
        end
        ST_SKIP_BLANK: begin
          if (!is_blank(b)) begin
            if (b == CH_LBRACE) begin
              obj_open_pos = text_pos;
              nest_lvl     = DEPTH_BITS'(1);
              in_quotes    = 1'b0;
              after_bslash = 1'b0;
              scan_st      = ST_IN_OBJECT;
            end else begin
              push_span(1'b0, '0, '0);
              emitted = 1'b1;
              scan_st = ST_IDLE;
            end
          end
        end
        ST_IN_OBJECT: begin
          if (in_quotes) begin
            if (after_bslash) after_bslash = 1'b0;
            else if (b == CH_BSLASH) after_bslash = 1'b1;
            else if (b == CH_QUOTE) in_quotes = 1'b0;
          end else if (b == CH_QUOTE) begin
            in_quotes = 1'b1;
          end else if (b == CH_LBRACE) begin
            if (nest_lvl != '1) nest_lvl++;   // saturates
          end else if (b == CH_RBRACE) begin
            nest_lvl--;
            if (nest_lvl == '0) begin
              push_span(1'b1, obj_open_pos, text_pos + 1'b1);
              emitted = 1'b1;
              scan_st = ST_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
    text_pos++;
    if (lst) begin
      if (scan_st != ST_IDLE && !emitted) push_span(1'b0, '0, '0);
      restart_scan();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready, with an optional long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      rx_hold_cycles--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Compare every result transfer with the oldest owed span.
  always @(posedge clk_i) begin
    span_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (span_q.size() == 0) begin
        $error("result with nothing owed: found=%0d span_start=%0d span_end=%0d",
               m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
        err_cnt++;
      end else begin
        want = span_q.pop_front();
        spans_checked++;
        if (want.found) found_cnt++;
        if (m_axis_tuser !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tdata[31:0] !== want.open_at) begin
          $error("span_start: expected %0d, got %0d", want.open_at, m_axis_tdata[31:0]);
          err_cnt++;
        end
        if (m_axis_tdata[63:32] !== want.close_after) begin
          $error("span_end: expected %0d, got %0d", want.close_after, m_axis_tdata[63:32]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) cycle_cnt++;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $error("run did not complete within %0d cycles, %0d spans owed", CYCLE_LIMIT,
           span_q.size());
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One byte transfer. tvalid stays high on return so back-to-back bytes flow;
  // wait_idle drops it when the stream pauses.
  task automatic send_byte(byte_t b, bit lst);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = lst;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_byte(b, lst);
    items_taken++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
    texts_sent++;
    text_buf.delete();
  endtask

  // Stream paused, every owed span delivered, pipeline drained.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (span_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    set_reg(idx, v);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Text builders
  // ---------------------------------------------------------------------------
  function automatic void put_byte(byte_t b);
    text_buf.push_back(b);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(byte_t'(s[i]));
  endfunction

  function automatic byte_t any_nonzero();
    return byte_t'($urandom_range(255, 1));
  endfunction

  function automatic void put_noise(int n);
    repeat (n) put_byte(any_nonzero());
  endfunction

  function automatic void put_key();
    put_byte(CH_QUOTE);
    for (int i = 0; i < key_eff_len(); i++) put_byte(key_byte_at(i));
    put_byte(CH_QUOTE);
  endfunction

  function automatic void put_blanks(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(5);
      put_byte(r == 5 ? CH_SPACE : byte_t'(CH_TAB + r));
    end
  endfunction

  function automatic byte_t not_colon();
    byte_t b;
    do b = any_nonzero(); while (b == CH_COLON);
    return b;
  endfunction

  function automatic byte_t bad_value();
    byte_t b;
    do b = any_nonzero(); while (is_blank(b) || b == CH_LBRACE);
    return b;
  endfunction

  // Plain object content: no quote and no brace.
  function automatic byte_t filler();
    byte_t b;
    do b = any_nonzero(); while (b == CH_QUOTE || b == CH_LBRACE || b == CH_RBRACE);
    return b;
  endfunction

  // Quoted string with escapes; escaped byte may be a quote or a brace.
  function automatic void put_string_tok();
    byte_t b;
    put_byte(CH_QUOTE);
    repeat ($urandom_range(6)) begin
      if ($urandom_range(5) == 0) begin
        put_byte(CH_BSLASH);
        put_byte(any_nonzero());
      end else begin
        do b = any_nonzero(); while (b == CH_QUOTE || b == CH_BSLASH);
        put_byte(b);
      end
    end
    put_byte(CH_QUOTE);
  endfunction

  function automatic void put_object(int toks);
    int lvl;
    lvl = 1;
    put_byte(CH_LBRACE);
    repeat (toks) begin
      case ($urandom_range(5))
        0: if (lvl < MAX_NEST) begin
             put_byte(CH_LBRACE);
             lvl++;
           end
        1: if (lvl > 1) begin
             put_byte(CH_RBRACE);
             lvl--;
           end
        2: put_string_tok();
        default: put_byte(filler());
      endcase
    end
    while (lvl > 0) begin
      put_byte(CH_RBRACE);
      lvl--;
    end
  endfunction

  // Mostly well-formed key/object texts, the rest broken or plain noise.
  function automatic void build_random_text();
    int pick;
    int n;
    pick = $urandom_range(99);
    put_noise($urandom_range(5));
    if (pick < 60) begin
      put_key();
      repeat ($urandom_range(2)) put_byte(not_colon());
      put_byte(CH_COLON);
      put_blanks($urandom_range(3));
      put_object($urandom_range(10));
      put_noise($urandom_range(3));
    end else if (pick < 68) begin
      put_key();
      put_byte(CH_COLON);
      put_blanks($urandom_range(3));
      put_byte(bad_value());
      put_noise($urandom_range(3));
    end else if (pick < 76) begin
      // object cut short: drop some of its tail
      put_key();
      put_byte(CH_COLON);
      put_blanks($urandom_range(2));
      put_object($urandom_range(8));
      repeat ($urandom_range(3, 1)) void'(text_buf.pop_back());
    end else if (pick < 82) begin
      if ($urandom_range(1)) begin
        put_key();
        put_byte(CH_COLON);
      end
      put_byte(CH_NUL);
      repeat ($urandom_range(3)) put_byte(byte_t'($urandom_range(255)));
    end else if (pick < 90) begin
      put_noise($urandom_range(12, 1));
    end else if (pick < 96) begin
      // key that breaks off before its closing quote
      n = $urandom_range(key_eff_len());
      put_byte(CH_QUOTE);
      for (int i = 0; i < n; i++) put_byte(key_byte_at(i));
      put_noise($urandom_range(4));
    end else begin
      repeat ($urandom_range(12, 1)) put_byte(byte_t'($urandom_range(255)));
    end
    if (text_buf.size() == 0) put_byte(any_nonzero());
  endfunction

  function automatic byte_t key_char();
    byte_t b;
    if ($urandom_range(7) == 0) b = any_nonzero();
    else b = byte_t'($urandom_range(8'h7E, 8'h23));
    return b;
  endfunction

  // Random key, mostly 1..16 bytes, sometimes empty or above the clamp.
  // Unused bytes and upper length bits get random junk.
  task automatic load_random_key();
    int          len;
    int          eff;
    byte_t       c;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_word;
    case ($urandom_range(9))
      0:       len = 0;
      1:       len = KEY_MAX;
      2:       len = $urandom_range(31, KEY_MAX + 1);
      default: len = $urandom_range(KEY_MAX, 1);
    endcase
    eff = (len > KEY_MAX) ? KEY_MAX : len;
    for (int i = 0; i < 16; i++) begin
      c = (i < eff) ? key_char() : byte_t'($urandom_range(255));
      if (i < 8) lo[8*i +: 8] = c;
      else hi[8*(i-8) +: 8] = c;
    end
    len_word = {$urandom, $urandom};
    len_word[KEY_LEN_W-1:0] = len[KEY_LEN_W-1:0];
    write_reg(CFG_KEY_LOW, lo);
    write_reg(CFG_KEY_HIGH, hi);
    write_reg(CFG_KEY_LEN, len_word);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Registers still at reset: the key is empty, so the pattern is two quotes.
  // Every blank kind before the brace, then braces and an escaped quote in a string.
  task automatic test_reset_key_and_blanks();
    put_str("\"\":\t\n");
    put_byte(8'h0B);
    put_byte(8'h0C);
    put_str("\r {\"}\\\"{\"}");
    put_str("z");
    send_text();
  endtask

  // All-ones key registers with an oversized length: clamped to 16 bytes of 0xFF.
  task automatic test_clamped_long_key();
    wait_idle();
    write_reg(CFG_KEY_LOW, '1);
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_KEY_LEN, 64'd31);
    put_byte(CH_QUOTE);
    repeat (KEY_MAX) put_byte(8'hFF);
    put_str("\":{}");   // found on the final byte
    send_text();
    wait_idle();
  endtask

  // Key "a:": its own colon must not count; a stray byte before the real colon.
  task automatic test_colon_inside_key();
    write_reg(CFG_KEY_LOW, 64'h3A61);
    write_reg(CFG_KEY_HIGH, '0);
    write_reg(CFG_KEY_LEN, 64'd2);
    put_str("\"a:\"x:{}");
    send_text();
  endtask

  task automatic test_value_not_object();
    put_str("\"a:\": 7}");
    send_text();
  endtask

  // Text ends while searching, seeking the colon, skipping blanks, inside the object.
  task automatic test_early_end_of_text();
    put_str("ab");
    send_text();
    put_str("\"a:\"");
    send_text();
    put_str("\"a:\": ");
    send_text();
    put_str("\"a:\":{{}");
    send_text();
  endtask

  // Zero byte ends the text; the bytes after it up to last stay silent.
  task automatic test_zero_byte();
    put_byte(CH_NUL);
    put_str("q");
    put_byte(CH_NUL);
    send_text();
    put_str("\"a:\":{");
    put_byte(CH_NUL);
    put_str("}");
    send_text();
  endtask

  // Receiver holds off while the sender keeps offering result-causing texts,
  // so the output register fills and the input stalls.
  task automatic test_output_backpressure();
    wait_idle();
    @(posedge clk_i);
    rx_hold_cycles = HOLD_OFF_CYCLES;
    repeat (5) begin
      put_byte(CH_NUL);
      send_text();
    end
    put_str("\"a:\":{}");
    send_text();
    wait_idle();
  endtask

  task automatic test_random_texts(int src_pct, int dst_pct);
    int first_item;
    int first_span;
    int n_texts;
    wait_idle();
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    first_item   = items_taken;
    first_span   = spans_predicted;
    n_texts      = 0;
    while (items_taken - first_item < RANDOM_ITEMS / 3 ||
           spans_predicted - first_span < MIN_SPANS_PER_PHASE) begin
      if (n_texts % TEXTS_PER_KEY == 0) begin
        wait_idle();
        load_random_key();
      end
      build_random_text();
      send_text();
      n_texts++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_KEY_LOW;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    key_lo        = '0;
    key_hi        = '0;
    key_len       = '0;
    restart_scan();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_key_and_blanks();
    test_clamped_long_key();
    test_colon_inside_key();
    test_value_not_object();
    test_early_end_of_text();
    test_zero_byte();
    test_output_backpressure();
    test_random_texts(36, 79);
    test_random_texts(79, 36);
    test_random_texts(0, 0);
    wait_idle();

    $display("Streamed %0d bytes in %0d texts: reset, clamped, colon-bearing and random keys.",
             items_taken, texts_sent);
    $display("Checked %0d results (%0d spans found), incl. early ends, zero bytes and hold-off.",
             spans_checked, found_cnt);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
